FILE: design/sorted_insert_queue_defines.svh
// assertion macros shared by the sorted insert queue modules
`ifndef SORTED_INSERT_QUEUE_DEFINES_SVH
`define SORTED_INSERT_QUEUE_DEFINES_SVH

// property checked on every clock edge outside reset
`define SIQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SIQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/siq_pkg.sv
// package: codes, command and status types of the sorted insert queue
package siq_pkg;

  localparam int unsigned DEPTH_DEF        = 16;
  localparam int unsigned KEY_BITS_DEF     = 16;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_INSERT     = 2'd2,
    REQ_POP        = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // where a new entry lands
  typedef enum logic [1:0] {
    WH_FRONT,
    WH_BACK,
    WH_ORDER
  } where_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_POP,
    OP_DROP,
    OP_EMPTY
  } op_e;

  typedef struct packed {
    logic   load;
    logic   compare;
    where_e where;
    op_e    op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

FILE: design/siq_ctrl.sv
// controller: request sequencing and command generation
module siq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     req_type_i,
  input  siq_pkg::stat_t stat_i,
  output siq_pkg::cmd_t  cmd_o,
  output logic           done_o
);

`include "sorted_insert_queue_defines.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e         state_q;
  siq_pkg::req_e  req_q;
  logic           done_q;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == S_IDLE) && start;
    cmd_o.compare = (state_q == S_CMP);
    unique case (req_q)
      siq_pkg::REQ_PUSH_FRONT: cmd_o.where = siq_pkg::WH_FRONT;
      siq_pkg::REQ_PUSH_BACK:  cmd_o.where = siq_pkg::WH_BACK;
      default:                 cmd_o.where = siq_pkg::WH_ORDER;
    endcase
    cmd_o.op = siq_pkg::OP_NONE;
    if (state_q == S_UPD) begin
      if (req_q == siq_pkg::REQ_POP) begin
        cmd_o.op = stat_i.empty ? siq_pkg::OP_EMPTY : siq_pkg::OP_POP;
      end else begin
        cmd_o.op = stat_i.full ? siq_pkg::OP_DROP : siq_pkg::OP_INSERT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= siq_pkg::REQ_PUSH_FRONT;
      done_q  <= 1'b0;
    end else begin
      // result beat follows the update cycle
      done_q <= (state_q == S_UPD);
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q   <= siq_pkg::req_e'(req_type_i);
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `SIQ_ASSERT(a_done_idle, done_q |-> state_q == S_IDLE, "result beat while busy")
  `SIQ_ASSERT(a_no_insert_full, cmd_o.op == siq_pkg::OP_INSERT |-> !stat_i.full, "insert into full list")
  `SIQ_ASSERT(a_no_pop_empty, cmd_o.op == siq_pkg::OP_POP |-> !stat_i.empty, "pop from empty list")

endmodule

FILE: design/siq_datapath.sv
// datapath: slot registers, key compare, shift and result registers
module siq_datapath #(
  parameter int unsigned DEPTH        = siq_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS     = siq_pkg::KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = siq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  siq_pkg::cmd_t                     cmd_i,
  output siq_pkg::stat_t                    stat_o,
  input  logic signed [KEY_BITS-1:0]        new_key_i,
  input  logic [PAYLOAD_BITS-1:0]           new_payload_i,
  output logic [1:0]                        status_o,
  output logic signed [KEY_BITS-1:0]        out_key_o,
  output logic [PAYLOAD_BITS-1:0]           out_payload_o,
  output logic                              out_valid_o,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count_o
);

`include "sorted_insert_queue_defines.svh"

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned LOG = $clog2(DEPTH);

  logic signed [KEY_BITS-1:0]     keys_q [DEPTH];
  logic [PAYLOAD_BITS-1:0]        pays_q [DEPTH];
  logic signed [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0]        pay_q;
  logic [CW-1:0]                  count_q;
  logic [DEPTH-1:0]               mask_q;
  logic [DEPTH-1:0]               mask_d;
  logic [DEPTH-1:0]               valid;
  logic [DEPTH-1:0]               ge;
  logic [DEPTH-1:0]               pre;
  logic [DEPTH-1:0]               mask_up;
  logic signed [KEY_BITS-1:0]     up_key [DEPTH];
  logic signed [KEY_BITS-1:0]     dn_key [DEPTH];
  logic [PAYLOAD_BITS-1:0]        up_pay [DEPTH];
  logic [PAYLOAD_BITS-1:0]        dn_pay [DEPTH];
  siq_pkg::status_e               status_q;
  logic signed [KEY_BITS-1:0]     out_key_q;
  logic [PAYLOAD_BITS-1:0]        out_pay_q;
  logic                           out_valid_q;

  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  // per slot compare against the new key
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = (CW'(i) < count_q);
      ge[i]    = valid[i] && (keys_q[i] >= key_q);
    end
  end

  // prefix or: slots at or after the first qualifying key
  always_comb begin
    pre = ge;
    for (int s = 0; s < LOG; s++) begin
      pre = pre | (pre << (1 << s));
    end
  end

  always_comb begin
    unique case (cmd_i.where)
      siq_pkg::WH_FRONT: mask_d = '1;
      siq_pkg::WH_BACK:  mask_d = ~valid;
      siq_pkg::WH_ORDER: mask_d = pre | ~valid;
      default:           mask_d = '1;
    endcase
  end

  // neighbor taps for the shift
  for (genvar g = 0; g < DEPTH; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign mask_up[g] = 1'b0;
      assign up_key[g]  = key_q;
      assign up_pay[g]  = pay_q;
    end else begin : g_mid
      assign mask_up[g] = mask_q[g-1];
      assign up_key[g]  = keys_q[g-1];
      assign up_pay[g]  = pays_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign dn_key[g] = keys_q[g];
      assign dn_pay[g] = pays_q[g];
    end else begin : g_inner
      assign dn_key[g] = keys_q[g+1];
      assign dn_pay[g] = pays_q[g+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= new_key_i;
      pay_q <= new_payload_i;
    end
    if (cmd_i.compare) begin
      mask_q <= mask_d;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.op == siq_pkg::OP_INSERT && mask_q[i]) begin
        keys_q[i] <= mask_up[i] ? up_key[i] : key_q;
        pays_q[i] <= mask_up[i] ? up_pay[i] : pay_q;
      end else if (cmd_i.op == siq_pkg::OP_POP) begin
        keys_q[i] <= dn_key[i];
        pays_q[i] <= dn_pay[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.op == siq_pkg::OP_INSERT) begin
      count_q <= count_q + 1'b1;
    end else if (cmd_i.op == siq_pkg::OP_POP) begin
      count_q <= count_q - 1'b1;
    end
  end

  // result beat registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      siq_pkg::OP_INSERT: begin
        status_q    <= siq_pkg::ST_DONE;
        out_key_q   <= mask_q[0] ? key_q : keys_q[0];
        out_pay_q   <= mask_q[0] ? pay_q : pays_q[0];
        out_valid_q <= 1'b1;
      end
      siq_pkg::OP_POP: begin
        status_q    <= siq_pkg::ST_DONE;
        out_key_q   <= keys_q[0];
        out_pay_q   <= pays_q[0];
        out_valid_q <= 1'b1;
      end
      siq_pkg::OP_DROP: begin
        status_q    <= siq_pkg::ST_FULL;
        out_key_q   <= keys_q[0];
        out_pay_q   <= pays_q[0];
        out_valid_q <= 1'b1;
      end
      siq_pkg::OP_EMPTY: begin
        status_q    <= siq_pkg::ST_EMPTY;
        out_key_q   <= '0;
        out_pay_q   <= '0;
        out_valid_q <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign status_o      = status_q;
  assign out_key_o     = out_key_q;
  assign out_payload_o = out_pay_q;
  assign out_valid_o   = out_valid_q;
  assign entry_count_o = count_q;

  `SIQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "fill count beyond depth")
  `SIQ_ASSERT_NEXT(a_ins_count, cmd_i.op == siq_pkg::OP_INSERT, count_q == CW'($past(count_q) + 1'b1), "insert did not grow count")
  `SIQ_ASSERT_NEXT(a_pop_count, cmd_i.op == siq_pkg::OP_POP, count_q == CW'($past(count_q) - 1'b1), "pop did not shrink count")

endmodule

FILE: design/sorted_insert_queue.sv
// top level of the sorted insert queue
//
//   channel   handshake             payload
//   request   start / busy          req_type_i, new_key_i, new_payload_i
//   result    done_o (one cycle)    status_o, out_key_o, out_payload_o,
//                                   out_valid_o, entry_count_o
//
// a request goes through latch, parallel key compare with prefix scan, then shift
// busy is high in the compare and update states after start is taken; done_o rises
// as busy falls and a new start is taken in that same cycle
// reset clears fill count and FSM; slot contents stay undefined until written
// the result beat is shown for one cycle and cannot be held off
module sorted_insert_queue #(
  parameter int unsigned DEPTH        = siq_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS     = siq_pkg::KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = siq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type_i,
  input  logic signed [KEY_BITS-1:0]  new_key_i,
  input  logic [PAYLOAD_BITS-1:0]     new_payload_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic signed [KEY_BITS-1:0]  out_key_o,
  output logic [PAYLOAD_BITS-1:0]     out_payload_o,
  output logic                        out_valid_o,
  output logic [$clog2(DEPTH+1)-1:0]  entry_count_o
);

  siq_pkg::cmd_t  cmd;
  siq_pkg::stat_t stat;

  siq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .done_o     (done_o)
  );

  siq_datapath #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .new_key_i     (new_key_i),
    .new_payload_i (new_payload_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .out_valid_o   (out_valid_o),
    .entry_count_o (entry_count_o)
  );

endmodule

FILE: bench/tb_sorted_insert_queue.sv
// self-checking bench for sorted_insert_queue: directed table, then random request mix vs a list model
module tb_sorted_insert_queue;
  import siq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int KEY_BITS     = KEY_BITS_DEF;
  localparam int PAYLOAD_BITS = PAYLOAD_BITS_DEF;
  localparam int CNT_BITS     = $clog2(DEPTH + 1);
  localparam int RAND_ITEMS   = 600;

  typedef struct packed {
    status_e                  status;
    logic signed [KEY_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0]  pay;
    logic                     valid;
    logic [CNT_BITS-1:0]      count;
  } outcome_t;

  typedef struct packed {
    req_e                       req;
    logic signed [KEY_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0]    pay;
    logic                       typed;
    outcome_t                   want;
  } dir_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [1:0]                  req_type_i;
  logic signed [KEY_BITS-1:0]  new_key_i;
  logic [PAYLOAD_BITS-1:0]     new_payload_i;
  logic                        done_o;
  logic [1:0]                  status_o;
  logic signed [KEY_BITS-1:0]  out_key_o;
  logic [PAYLOAD_BITS-1:0]     out_payload_o;
  logic                        out_valid_o;
  logic [CNT_BITS-1:0]         entry_count_o;

  logic signed [KEY_BITS-1:0]  list_keys [DEPTH];
  logic [PAYLOAD_BITS-1:0]     list_pays [DEPTH];
  int                          list_fill;

  outcome_t                    pending_results[$];
  dir_row_t                    dir_rows [25];
  int unsigned                 mismatches;
  int unsigned                 checked_beats;
  int unsigned                 sent_beats;
  int unsigned                 full_drops;
  int unsigned                 empty_pops;
  bit                          gaps_on;

  sorted_insert_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .new_key_i     (new_key_i),
    .new_payload_i (new_payload_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .out_valid_o   (out_valid_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("sorted_insert_queue: mismatch");
    $finish;
  end

  function automatic outcome_t apply_request(req_e req, logic signed [KEY_BITS-1:0] key,
                                             logic [PAYLOAD_BITS-1:0] pay);
    outcome_t res;
    int       pos;
    int       i;
    res.status = ST_DONE;
    res.key    = '0;
    res.pay    = '0;
    res.valid  = 1'b0;
    if (req == REQ_POP) begin
      if (list_fill == 0) begin
        res.status = ST_EMPTY;
        empty_pops++;
      end else begin
        res.key   = list_keys[0];
        res.pay   = list_pays[0];
        res.valid = 1'b1;
        for (i = 1; i < list_fill; i++) begin
          list_keys[i-1] = list_keys[i];
          list_pays[i-1] = list_pays[i];
        end
        list_fill--;
      end
    end else begin
      if (list_fill >= DEPTH) begin
        res.status = ST_FULL;
        full_drops++;
      end else begin
        case (req)
          REQ_PUSH_FRONT: pos = 0;
          REQ_PUSH_BACK:  pos = list_fill;
          default: begin
            // first stored key at or above the new one, signed
            pos = list_fill;
            for (i = list_fill - 1; i >= 0; i--) begin
              if (list_keys[i] >= key) pos = i;
            end
          end
        endcase
        for (i = list_fill; i > pos; i--) begin
          list_keys[i] = list_keys[i-1];
          list_pays[i] = list_pays[i-1];
        end
        list_keys[pos] = key;
        list_pays[pos] = pay;
        list_fill++;
      end
      if (list_fill > 0) begin
        res.key   = list_keys[0];
        res.pay   = list_pays[0];
        res.valid = 1'b1;
      end
    end
    res.count = CNT_BITS'(list_fill);
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_request(req_e req, logic signed [KEY_BITS-1:0] key,
                              logic [PAYLOAD_BITS-1:0] pay, logic typed, outcome_t want);
    outcome_t predicted;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 34) begin
      start         <= 1'b0;
      req_type_i    <= 2'($urandom);
      new_key_i     <= KEY_BITS'($urandom);
      new_payload_i <= PAYLOAD_BITS'($urandom);
      @(negedge clk_i);
    end
    start         <= 1'b1;
    req_type_i    <= req;
    new_key_i     <= key;
    new_payload_i <= pay;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = apply_request(req, key, pay);
    pending_results.push_back(typed ? want : predicted);
    sent_beats++;
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, status %h key %h", $time, status_o,
                 out_key_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(status_o));
        check_field("out_key", 64'(want.key), 64'(out_key_o));
        check_field("out_payload", 64'(want.pay), 64'(out_payload_o));
        check_field("out_valid", 64'(want.valid), 64'(out_valid_o));
        check_field("entry_count", 64'(want.count), 64'(entry_count_o));
        checked_beats++;
      end
    end
  end

  initial begin
    outcome_t                   no_want;
    req_e                       r;
    logic signed [KEY_BITS-1:0] k;
    logic [PAYLOAD_BITS-1:0]    p;
    int                         push_pct;
    int                         n;
    int                         wait_cycles;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_type_i    = REQ_PUSH_FRONT;
    new_key_i     = '0;
    new_payload_i = '0;
    list_fill     = 0;
    mismatches    = 0;
    checked_beats = 0;
    sent_beats    = 0;
    full_drops    = 0;
    empty_pops    = 0;
    gaps_on       = 1'b1;
    push_pct      = 50;
    no_want       = '0;

    dir_rows = '{
      '{REQ_POP,        16'sh0000, 32'h00000000, 1'b1, '{ST_EMPTY, 16'sh0000, 32'h0, 1'b0, 5'd0}},
      '{REQ_INSERT,     16'sh0000, 32'h00000000, 1'b1, '{ST_DONE, 16'sh0000, 32'h0, 1'b1, 5'd1}},
      '{REQ_POP,        16'sh0000, 32'h00000000, 1'b1, '{ST_DONE, 16'sh0000, 32'h0, 1'b1, 5'd0}},
      '{REQ_PUSH_BACK,  16'sh7fff, 32'hffffffff, 1'b1,
        '{ST_DONE, 16'sh7fff, 32'hffffffff, 1'b1, 5'd1}},
      '{REQ_INSERT,     16'sh8000, 32'h00000000, 1'b1, '{ST_DONE, 16'sh8000, 32'h0, 1'b1, 5'd2}},
      '{REQ_INSERT,     16'sh0064, 32'h11110001, 1'b0, '0},
      // equal key lands ahead of the stored one
      '{REQ_INSERT,     16'sh0064, 32'h11110002, 1'b0, '0},
      '{REQ_PUSH_FRONT, 16'sh0005, 32'ha5a5a5a5, 1'b0, '0},
      '{REQ_PUSH_BACK,  16'shffff, 32'h5a5a5a5a, 1'b0, '0},
      '{REQ_INSERT,     16'sh7fff, 32'h00000003, 1'b0, '0},
      '{REQ_INSERT,     16'sh8000, 32'h00000004, 1'b0, '0},
      '{REQ_PUSH_FRONT, 16'sh0001, 32'h80000000, 1'b0, '0},
      '{REQ_PUSH_BACK,  16'sh0000, 32'h00000001, 1'b0, '0},
      '{REQ_INSERT,     16'sh0000, 32'h00000005, 1'b0, '0},
      '{REQ_INSERT,     16'shfffe, 32'h00000006, 1'b0, '0},
      '{REQ_PUSH_FRONT, 16'sh4000, 32'h0f0f0f0f, 1'b0, '0},
      '{REQ_INSERT,     16'shc000, 32'hf0f0f0f0, 1'b0, '0},
      '{REQ_PUSH_BACK,  16'sh2000, 32'h12345678, 1'b0, '0},
      '{REQ_INSERT,     16'sh0064, 32'h87654321, 1'b0, '0},
      // list is full from here
      '{REQ_PUSH_BACK,  16'sh1234, 32'h0badf00d, 1'b0, '0},
      '{REQ_PUSH_FRONT, 16'sh8000, 32'hffffffff, 1'b0, '0},
      '{REQ_INSERT,     16'sh7fff, 32'h00000000, 1'b0, '0},
      '{REQ_POP,        16'sh0000, 32'h00000000, 1'b0, '0},
      '{REQ_POP,        16'sh7fff, 32'hffffffff, 1'b0, '0},
      '{REQ_POP,        16'sh8000, 32'h00000000, 1'b0, '0}
    };

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].key, dir_rows[i].pay, dir_rows[i].typed,
                   dir_rows[i].want);
    end

    for (n = 0; n < RAND_ITEMS; n++) begin
      // phases that lean toward filling, draining or churning the list
      if (n % 60 == 0) begin
        case ($urandom_range(3))
          0:       push_pct = 90;
          1:       push_pct = 12;
          2:       push_pct = 55;
          default: push_pct = 75;
        endcase
      end
      gaps_on = !(n >= 250 && n < 400);
      case ($urandom_range(3))
        0: k = KEY_BITS'($urandom_range(8) - 4);
        1: begin
          case ($urandom_range(3))
            0:       k = 16'sh8000;
            1:       k = 16'sh7fff;
            2:       k = 16'sh0000;
            default: k = 16'shffff;
          endcase
        end
        default: k = KEY_BITS'($urandom);
      endcase
      p = PAYLOAD_BITS'($urandom);
      if ($urandom_range(99) < push_pct) r = req_e'($urandom_range(2));
      else r = REQ_POP;
      send_request(r, k, p, 1'b0, no_want);
    end

    @(negedge clk_i);
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatches += pending_results.size();
    end

    $display("sent %0d requests, checked %0d result beats, %0d mismatching fields",
             sent_beats, checked_beats, mismatches);
    $display("%0d inserts dropped on a full list, %0d pops on an empty list",
             full_drops, empty_pops);
    if (mismatches == 0) begin
      $display("sorted_insert_queue: match");
    end else begin
      $display("sorted_insert_queue: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/siq_pkg.sv
design/siq_ctrl.sv
design/siq_datapath.sv
design/sorted_insert_queue.sv
bench/tb_sorted_insert_queue.sv
